// ===== rtl/core/dfr_pkg.sv =====
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types and constants of the serial packet deframer: parse phases,
// verdict codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package dfr_pkg;

    // Frame constants
    localparam logic [7:0]  HEADER_BYTE    = 8'h42;
    localparam logic [7:0]  BROADCAST_ADDR = 8'hff;
    localparam logic [15:0] CRC_POLY       = 16'h1021;

    // Register reset values
    localparam logic [7:0] STATION_ADDR_RST = 8'd254;
    localparam logic [7:0] TIMEOUT_RST      = 8'd10;
    localparam logic [9:0] MAX_PAYLOAD_RST  = 10'd280;

    // Register indexes on the write port
    localparam logic [1:0] CFG_STATION_ADDR = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT      = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD  = 2'd2;

    // Input operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict codes
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_CRC_ERR  = 2'd1;
    localparam logic [1:0] ST_NOT_ADDR = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_ADDR   = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_LEN_HI = 3'd3,
        PH_TYPE   = 3'd4,
        PH_DATA   = 3'd5,
        PH_CRC_LO = 3'd6,
        PH_CRC_HI = 3'd7
    } phase_t;

    typedef struct packed {
        logic [7:0] station_address;
        logic [7:0] timeout_ticks;
        logic [9:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [9:0] byte_index;
        logic [1:0] status;
        logic [7:0] packet_address;
        logic [7:0] packet_type;
        logic [9:0] payload_length;
    } res_t;

endpackage

// ===== rtl/core/dfr_crc_step.sv =====
// ----------------------------------------------------------------------------
// dfr_crc_step
// One byte of CRC-16 CCITT, MSB first, eight bit steps unrolled.
// ----------------------------------------------------------------------------
module dfr_crc_step
    import dfr_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    // Shift the byte through the register one bit at a time
    always_comb begin
        logic [15:0] c;
        logic        top;
        c   = crc_in;
        top = 1'b0;
        for (int k = 7; k >= 0; k--) begin
            top = c[15] ^ data_in[k];
            c   = {c[14:0], 1'b0};
            if (top) begin
                c = c ^ CRC_POLY;
            end
        end
        crc_out = c;
    end

endmodule

// ===== rtl/core/dfr_parser.sv =====
// ----------------------------------------------------------------------------
// dfr_parser
// Frame parser: tracks the parse phase, packet fields, running CRC and the
// packet timer; emits a payload result per data byte and a CRC-end verdict.
// ----------------------------------------------------------------------------
module dfr_parser
    import dfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_valid,
    input  logic       item_op,
    input  logic [7:0] item_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output res_t       res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  held_address_reg, held_address_next;
    logic [15:0] declared_length_reg, declared_length_next;
    logic [7:0]  held_type_reg, held_type_next;
    logic [9:0]  payload_count_reg, payload_count_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [7:0]  timer_reg, timer_next;

    logic        is_byte;
    logic        is_tick;
    logic        timed_out;
    phase_t      cur_phase;
    logic [15:0] crc_src;
    logic [15:0] crc_fed;
    logic [15:0] len_full;
    logic [9:0]  count_inc;
    logic [15:0] rx_crc;
    logic        addr_match;

    assign is_byte   = item_valid && (item_op == OP_BYTE);
    assign is_tick   = item_valid && (item_op == OP_TICK);
    assign timed_out = (timer_reg >= cfg.timeout_ticks);
    assign cur_phase = timed_out ? PH_HUNT : phase_reg;
    assign crc_src   = (cur_phase == PH_HUNT) ? 16'h0000 : running_crc_reg;
    assign len_full  = {item_byte, declared_length_reg[7:0]};
    assign count_inc = payload_count_reg + 10'd1;
    assign rx_crc    = {item_byte, crc_low_reg};
    assign addr_match = (held_address_reg == cfg.station_address) ||
                        (held_address_reg == BROADCAST_ADDR);

    dfr_crc_step u_crc (
        .crc_in  (crc_src),
        .data_in (item_byte),
        .crc_out (crc_fed)
    );

    // Next parse phase
    always_comb begin
        phase_next = phase_reg;
        if (is_byte) begin
            phase_next = cur_phase;
            unique case (cur_phase)
                PH_HUNT: begin
                    if (item_byte == HEADER_BYTE) phase_next = PH_ADDR;
                end
                PH_ADDR: begin
                    if (item_byte != HEADER_BYTE) phase_next = PH_LEN_LO;
                end
                PH_LEN_LO: phase_next = PH_LEN_HI;
                PH_LEN_HI: begin
                    phase_next = (len_full > {6'b0, cfg.max_payload}) ? PH_HUNT : PH_TYPE;
                end
                PH_TYPE: begin
                    phase_next = (declared_length_reg != 16'd0) ? PH_DATA : PH_CRC_LO;
                end
                PH_DATA: begin
                    if ({6'b0, count_inc} >= declared_length_reg) phase_next = PH_CRC_LO;
                end
                PH_CRC_LO: phase_next = PH_CRC_HI;
                PH_CRC_HI: phase_next = PH_HUNT;
                default:   phase_next = PH_HUNT;
            endcase
        end
    end

    // Field registers, CRC, timer and result
    always_comb begin
        held_address_next    = held_address_reg;
        declared_length_next = declared_length_reg;
        held_type_next       = held_type_reg;
        payload_count_next   = payload_count_reg;
        running_crc_next     = running_crc_reg;
        crc_low_next         = crc_low_reg;
        timer_next           = timer_reg;

        res_valid          = 1'b0;
        res.kind           = KIND_PAYLOAD;
        res.data_byte      = item_byte;
        res.byte_index     = payload_count_reg;
        res.status         = ST_ACCEPTED;
        res.packet_address = held_address_reg;
        res.packet_type    = held_type_reg;
        res.payload_length = declared_length_reg[9:0];

        // Advance the timer, saturating
        if (is_tick && (timer_reg != 8'hff)) begin
            timer_next = timer_reg + 8'd1;
        end

        if (is_byte) begin
            unique case (cur_phase)
                PH_HUNT: begin
                    if (item_byte == HEADER_BYTE) begin
                        running_crc_next = crc_fed;
                        timer_next       = 8'd0;
                    end
                end
                PH_ADDR: begin
                    held_address_next = item_byte;
                    if (item_byte != HEADER_BYTE) running_crc_next = crc_fed;
                end
                PH_LEN_LO: begin
                    declared_length_next = {8'h00, item_byte};
                    running_crc_next     = crc_fed;
                end
                PH_LEN_HI: begin
                    declared_length_next = len_full;
                    running_crc_next     = crc_fed;
                end
                PH_TYPE: begin
                    held_type_next     = item_byte;
                    running_crc_next   = crc_fed;
                    payload_count_next = 10'd0;
                end
                PH_DATA: begin
                    running_crc_next   = crc_fed;
                    payload_count_next = count_inc;
                    res_valid          = 1'b1;
                end
                PH_CRC_LO: begin
                    crc_low_next = item_byte;
                end
                PH_CRC_HI: begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_VERDICT;
                    res.data_byte  = 8'h00;
                    res.byte_index = 10'd0;
                    if (!addr_match) begin
                        res.status = ST_NOT_ADDR;
                    end else if (rx_crc != running_crc_reg) begin
                        res.status = ST_CRC_ERR;
                    end else begin
                        res.status = ST_ACCEPTED;
                    end
                end
                default: ;
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_HUNT;
            held_address_reg    <= 8'h00;
            declared_length_reg <= 16'h0000;
            held_type_reg       <= 8'h00;
            payload_count_reg   <= 10'd0;
            running_crc_reg     <= 16'h0000;
            crc_low_reg         <= 8'h00;
            timer_reg           <= 8'h00;
        end else begin
            phase_reg           <= phase_next;
            held_address_reg    <= held_address_next;
            declared_length_reg <= declared_length_next;
            held_type_reg       <= held_type_next;
            payload_count_reg   <= payload_count_next;
            running_crc_reg     <= running_crc_next;
            crc_low_reg         <= crc_low_next;
            timer_reg           <= timer_next;
        end
    end

`ifndef ASSERT_OFF
    a_verdict_ends_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && (res.kind == KIND_VERDICT) |=> phase_reg == PH_HUNT)
        else $error("verdict did not return parser to hunting");

    a_count_below_length: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> {6'b0, payload_count_reg} < declared_length_reg)
        else $error("payload count reached declared length inside payload");

    a_length_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> declared_length_reg[15:10] == 6'b0)
        else $error("oversized length reached payload phase");
`endif

endmodule

// ===== rtl/core/dfr_out_buf.sv =====
// ----------------------------------------------------------------------------
// dfr_out_buf
// Result register with a skid stage, so the parser keeps taking beats while
// a result waits on the output.
// ----------------------------------------------------------------------------
module dfr_out_buf
    import dfr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  res_t in_res,
    output logic in_ready,
    output logic out_valid,
    output res_t out_res,
    input  logic out_ready
);

    logic out_valid_reg, out_valid_next;
    res_t out_res_reg, out_res_next;
    logic skid_valid_reg, skid_valid_next;
    res_t skid_res_reg, skid_res_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // Move results between the output and skid registers
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_res_next   = in_res;
            end
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_res_next   = in_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

`ifndef ASSERT_OFF
    a_skid_behind_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output is empty");

    a_stall_fills_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ready && in_valid |=> skid_valid_reg)
        else $error("result lost during output stall");

    a_hold_while_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_res_reg))
        else $error("result changed while output stalled");
`endif

endmodule

// ===== rtl/core/serial_packet_deframer_crc_check.sv =====
// ----------------------------------------------------------------------------
// serial_packet_deframer_crc_check
// Byte-stream packet deframer with CRC-16 CCITT check and payload forwarding.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while s_tready is high; parser and byte-wide
// CRC update are combinational and results are registered in the output stage.
// A skid stage holds one result; s_tready drops while it is full.
// Reset: synchronous, active low; parser returns to hunting, registers take
// address 254, timeout 10 ticks, max payload 280.
// ----------------------------------------------------------------------------
module serial_packet_deframer_crc_check
    import dfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic [0:0]  s_tuser,   // [0] operation
    // Result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] data_byte, [17:8] byte_index,
                                   // [19:18] status, [27:20] packet_address,
                                   // [35:28] packet_type, [45:36] payload_length
    output logic [0:0]  m_tuser,   // [0] kind
    // Register writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    cfg_t cfg_reg;
    logic accept;
    logic res_valid;
    res_t res;
    res_t out_res;

    assign accept = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.station_address <= STATION_ADDR_RST;
            cfg_reg.timeout_ticks   <= TIMEOUT_RST;
            cfg_reg.max_payload     <= MAX_PAYLOAD_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_STATION_ADDR: cfg_reg.station_address <= cfg_data[7:0];
                CFG_TIMEOUT:      cfg_reg.timeout_ticks   <= cfg_data[7:0];
                CFG_MAX_PAYLOAD:  cfg_reg.max_payload     <= cfg_data;
                default: ;
            endcase
        end
    end

    dfr_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (accept),
        .item_op    (s_tuser[0]),
        .item_byte  (s_tdata),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    dfr_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_ready (m_tready)
    );

    // Pack the result beat
    assign m_tuser[0] = out_res.kind;
    assign m_tdata = {2'b00, out_res.payload_length, out_res.packet_type,
                      out_res.packet_address, out_res.status,
                      out_res.byte_index, out_res.data_byte};

endmodule
